// ----- design/ppsc_pkg.sv -----
package ppsc_pkg;

  localparam int FRACTION_BITS   = 16;
  localparam int WORD_BITS       = 24;
  localparam int BEND_HOLD_TICKS = 25;
  localparam int ANGLE_Q         = 30;

  localparam int DW           = 64;
  localparam int MUL_BITS     = 26;
  localparam int DIV_STEPS    = 64;
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 30;

  typedef logic signed [DW-1:0] dword_t;

  localparam dword_t ONE   = dword_t'(1) <<< FRACTION_BITS;
  localparam dword_t QC_03 = dword_t'(((3 << FRACTION_BITS) + 50) / 100);
  localparam dword_t QC_05 = dword_t'(((5 << FRACTION_BITS) + 50) / 100);
  localparam dword_t QC_08 = dword_t'(((8 << FRACTION_BITS) + 50) / 100);
  localparam dword_t QC_12 = dword_t'(((12 << FRACTION_BITS) + 50) / 100);
  localparam dword_t QC_15 = dword_t'(((15 << FRACTION_BITS) + 50) / 100);
  localparam dword_t QC_20 = dword_t'(((20 << FRACTION_BITS) + 50) / 100);
  localparam dword_t QC_25 = dword_t'(((25 << FRACTION_BITS) + 50) / 100);
  localparam dword_t QC_30 = dword_t'(((30 << FRACTION_BITS) + 50) / 100);
  localparam dword_t QC_35 = dword_t'(((35 << FRACTION_BITS) + 50) / 100);
  localparam dword_t QC_40 = dword_t'(((40 << FRACTION_BITS) + 50) / 100);
  localparam dword_t LA_3M = dword_t'(3) <<< FRACTION_BITS;
  localparam dword_t LA_2M = dword_t'(2) <<< FRACTION_BITS;

  localparam dword_t WLIM       = (dword_t'(1) <<< (WORD_BITS - 1)) - 1;
  localparam dword_t ALIM       = dword_t'(1) <<< (FRACTION_BITS + 20);
  localparam dword_t TLIM       = dword_t'(1) <<< 38;
  localparam dword_t CORDIC_ONE = dword_t'(1) <<< ANGLE_Q;

  typedef enum logic [2:0] {
    REG_WHEELBASE  = 3'd0,
    REG_MAX_ANGLE  = 3'd1,
    REG_SPEED_GAIN = 3'd2,
    REG_LA_FLOOR   = 3'd3,
    REG_LA_CEIL    = 3'd4,
    REG_BEND_THR   = 3'd5,
    REG_STEP_LIMIT = 3'd6,
    REG_START_LA   = 3'd7
  } reg_idx_t;

  function automatic dword_t imin(input dword_t a, input dword_t b);
    imin = (a < b) ? a : b;
  endfunction

  function automatic dword_t imax(input dword_t a, input dword_t b);
    imax = (a > b) ? a : b;
  endfunction

  function automatic dword_t sat(input dword_t v, input dword_t lim);
    if (v > lim) sat = lim;
    else if (v < -lim) sat = -lim;
    else sat = v;
  endfunction

  // atan(2^-i) in Q30
  function automatic dword_t cordic_angle(input logic [4:0] i);
    case (i)
      5'd0: cordic_angle = dword_t'(64'h3243F6A8);
      5'd1: cordic_angle = dword_t'(64'h1DAC6705);
      5'd2: cordic_angle = dword_t'(64'h0FADBAFC);
      5'd3: cordic_angle = dword_t'(64'h07F56EA6);
      5'd4: cordic_angle = dword_t'(64'h03FEAB76);
      5'd5: cordic_angle = dword_t'(64'h01FFD55B);
      5'd6: cordic_angle = dword_t'(64'h00FFFAAA);
      5'd7: cordic_angle = dword_t'(64'h007FFF55);
      5'd8: cordic_angle = dword_t'(64'h003FFFEA);
      5'd9: cordic_angle = dword_t'(64'h001FFFFD);
      default: cordic_angle = (dword_t'(1) <<< (ANGLE_Q - int'(i))) - 1;
    endcase
  endfunction

endpackage

// ----- design/pure_pursuit_steering_controller_top.sv -----
// Pure-pursuit steering controller. One input transaction per control tick
// (lateral error, speed, path curvature, signed Q.16) yields one output
// transaction (steering angle, lookahead used, tight-mode flag). The block
// works on one tick at a time: a sequencer drives a bit-serial multiplier
// (26 steps), a restoring divider (64 steps), a square-root unit (32 steps)
// and a CORDIC engine (30 steps), each loaded by the state that starts it.
// A tick runs up to five divides and up to eight multiplies. The curvature
// shrink path (divide plus square root) and the normal smoothing multiplies
// run only when the tick needs them. The input is not taken while a tick is
// in flight; the finished result sits in the output register, so the next
// tick can be accepted while it waits. Configuration writes take effect at
// once; writing the start lookahead also reloads the smoothing state.
module pure_pursuit_steering_controller_top
  import ppsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] lateral_error, [47:24] vehicle_speed, [71:48] path_curve
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [17:0] steer_angle, [39:18] lookahead_used
  output logic [39:0] m_axis_tdata,
  // [0] tight_mode
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  typedef enum logic [26:0] {
    ST_IDLE       = 27'd1 << 0,
    ST_MUL_BASE   = 27'd1 << 1,
    ST_BASE_SET   = 27'd1 << 2,
    ST_DIV_RATIO  = 27'd1 << 3,
    ST_SQRT       = 27'd1 << 4,
    ST_MUL_SHRINK = 27'd1 << 5,
    ST_SHRINK_SET = 27'd1 << 6,
    ST_CAPS       = 27'd1 << 7,
    ST_MUL_SM_A   = 27'd1 << 8,
    ST_MUL_SM_B   = 27'd1 << 9,
    ST_SM_SET     = 27'd1 << 10,
    ST_LOOK       = 27'd1 << 11,
    ST_TAN        = 27'd1 << 12,
    ST_DIV_TAN    = 27'd1 << 13,
    ST_DIV_MAXC   = 27'd1 << 14,
    ST_REQ_SEL    = 27'd1 << 15,
    ST_DIV_T      = 27'd1 << 16,
    ST_DIV_REQ    = 27'd1 << 17,
    ST_REQ_SET    = 27'd1 << 18,
    ST_MUL_FB     = 27'd1 << 19,
    ST_ATAN_FB    = 27'd1 << 20,
    ST_MUL_FF     = 27'd1 << 21,
    ST_ATAN_FF    = 27'd1 << 22,
    ST_FF_SET     = 27'd1 << 23,
    ST_MUL_W_A    = 27'd1 << 24,
    ST_MUL_W_B    = 27'd1 << 25,
    ST_FINISH     = 27'd1 << 26
  } state_t;

  state_t state, state_after;

  // configuration
  logic [19:0] r_wb;
  logic [16:0] r_amax;
  logic [18:0] r_gain;
  logic [20:0] r_floor;
  logic [21:0] r_ceil;
  logic [18:0] r_thr;
  logic [16:0] r_step;

  // tick state
  logic signed [WORD_BITS-1:0] sl;
  logic signed [17:0]          last_angle;
  logic                        last_neg;
  logic [4:0]                  hold;
  logic                        tight;

  // per-tick working registers
  logic signed [23:0]          err_q, spd_q, crv_q;
  logic [23:0]                 ac_q, ae_q;
  logic signed [WORD_BITS-1:0] base;
  logic                        emer;
  logic [16:0]                 kq, wreg;
  logic [21:0]                 dyn;
  logic [38:0]                 maxc, req;
  logic signed [17:0]          fb, ff;
  dword_t                      tmp;

  // shared arithmetic units
  logic       busy;
  logic [6:0] cnt, unit_last;
  logic       u_mul, u_div, u_sqrt, u_cor;
  dword_t      ma, macc;
  logic [MUL_BITS-1:0] mb;
  logic [63:0] dn, dd, drem, div_sh;
  logic        div_ge;
  logic [63:0] sn, sr, sbit, sq_sum;
  logic        sq_ge;
  dword_t      cx, cy, cz, shx, shy, cang;
  logic        cvec, csig;

  // input decode
  logic signed [23:0] in_err, in_spd, in_crv;
  logic [23:0]        in_ac, in_ae;

  // wide views and glue
  dword_t ac_w, ae_w, spd_w, crv_w, base_w, sl_w, hair_w, ceil_w, tgt_w;
  dword_t amax_w, cap_w, base_capped, sm_nl, look_dyn, atan_arg, atan_round;
  dword_t fb_w, ff_w, a0, delta, a1, fin_ang, step_w, last_w;
  logic [21:0] wb3;
  logic [20:0] hair;
  logic [16:0] amax, w_new;
  logic [63:0] t_sat, maxc_new;
  logic        same;

  assign s_axis_tready = (state == ST_IDLE);

  assign in_err = s_axis_tdata[23:0];
  assign in_spd = s_axis_tdata[47:24];
  assign in_crv = s_axis_tdata[71:48];
  assign in_ac  = in_crv[23] ? 24'(-in_crv) : 24'(in_crv);
  assign in_ae  = in_err[23] ? 24'(-in_err) : 24'(in_err);

  always_comb begin
    ac_w   = dword_t'(ac_q);
    ae_w   = dword_t'(ae_q);
    spd_w  = dword_t'(spd_q);
    crv_w  = dword_t'(crv_q);
    base_w = dword_t'(base);
    sl_w   = dword_t'(sl);
    fb_w   = dword_t'(fb);
    ff_w   = dword_t'(ff);
    ceil_w = dword_t'(r_ceil);
    step_w = dword_t'(r_step);
    last_w = dword_t'(last_angle);

    // hairpin lookahead: max(1.5 * wheelbase, floor)
    wb3    = {2'b00, r_wb} + {1'b0, r_wb, 1'b0};
    hair   = (wb3[21:1] > r_floor) ? wb3[21:1] : r_floor;
    hair_w = dword_t'(hair);
    tgt_w  = imin(hair_w, ceil_w);

    amax   = (r_amax > 17'(ONE)) ? 17'(ONE) : r_amax;
    amax_w = dword_t'(amax);

    base_capped = base_w;
    if (ac_w > QC_05) base_capped = imin(base_capped, LA_3M);
    if (ac_w > QC_15) base_capped = imin(base_capped, LA_2M);

    sm_nl = (tmp + macc) >>> FRACTION_BITS;
    if (!emer && tight) sm_nl = imin(sm_nl, base_w);

    if (ac_w < QC_05) cap_w = ceil_w;
    else if (ac_w < QC_15) cap_w = LA_3M;
    else cap_w = LA_2M;
    look_dyn = imin(imin(imax(sl_w, hair_w), ceil_w), cap_w);

    maxc_new = (dn > 64'(TLIM)) ? 64'(TLIM) : dn;
    t_sat    = (dn > 64'(TLIM)) ? 64'(TLIM) : dn;

    atan_arg   = sat(macc >>> FRACTION_BITS, ALIM);
    atan_round = (cz + (dword_t'(1) <<< (ANGLE_Q - 1 - FRACTION_BITS)))
                 >>> (ANGLE_Q - FRACTION_BITS);

    // feedforward weight: only when both angles agree in direction
    same  = (fb_w >= 0 && atan_round >= 0) || (fb_w <= 0 && atan_round <= 0);
    w_new = same ? 17'(QC_20) : 17'd0;
    if (ac_w > QC_05 && ac_w < QC_20 && same) w_new = 17'(QC_40);
    if (ae_w < QC_20 && same && w_new < 17'(QC_30)) w_new = 17'(QC_30);

    // final clamp and per-tick rate limit
    a0    = sat((tmp + macc) >>> FRACTION_BITS, amax_w);
    delta = a0 - last_w;
    if (delta > step_w) a1 = last_w + step_w;
    else if (delta < -step_w) a1 = last_w - step_w;
    else a1 = a0;
    fin_ang = sat(a1, amax_w);
  end

  // unit selection
  assign u_mul  = (state == ST_MUL_BASE) || (state == ST_MUL_SHRINK) ||
                  (state == ST_MUL_SM_A) || (state == ST_MUL_SM_B) ||
                  (state == ST_MUL_FB) || (state == ST_MUL_FF) ||
                  (state == ST_MUL_W_A) || (state == ST_MUL_W_B);
  assign u_div  = (state == ST_DIV_RATIO) || (state == ST_DIV_TAN) ||
                  (state == ST_DIV_MAXC) || (state == ST_DIV_T) ||
                  (state == ST_DIV_REQ);
  assign u_sqrt = (state == ST_SQRT);
  assign u_cor  = (state == ST_TAN) || (state == ST_ATAN_FB) || (state == ST_ATAN_FF);

  always_comb begin
    if (u_mul) unit_last = 7'(MUL_BITS - 1);
    else if (u_div) unit_last = 7'(DIV_STEPS - 1);
    else if (u_sqrt) unit_last = 7'(SQRT_STEPS - 1);
    else unit_last = 7'(CORDIC_STEPS - 1);
  end

  always_comb begin
    case (state)
      ST_MUL_BASE:   state_after = ST_BASE_SET;
      ST_DIV_RATIO:  state_after = ST_SQRT;
      ST_SQRT:       state_after = ST_MUL_SHRINK;
      ST_MUL_SHRINK: state_after = ST_SHRINK_SET;
      ST_MUL_SM_A:   state_after = ST_MUL_SM_B;
      ST_MUL_SM_B:   state_after = ST_SM_SET;
      ST_TAN:        state_after = ST_DIV_TAN;
      ST_DIV_TAN:    state_after = ST_DIV_MAXC;
      ST_DIV_MAXC:   state_after = ST_REQ_SEL;
      ST_DIV_T:      state_after = ST_DIV_REQ;
      ST_DIV_REQ:    state_after = ST_REQ_SET;
      ST_MUL_FB:     state_after = ST_ATAN_FB;
      ST_ATAN_FB:    state_after = ST_MUL_FF;
      ST_MUL_FF:     state_after = ST_ATAN_FF;
      ST_ATAN_FF:    state_after = ST_FF_SET;
      ST_MUL_W_A:    state_after = ST_MUL_W_B;
      ST_MUL_W_B:    state_after = ST_FINISH;
      default:       state_after = ST_IDLE;
    endcase
  end

  // one step of each serial unit
  always_comb begin
    div_sh = {drem[62:0], dn[63]};
    div_ge = (div_sh >= dd);
    sq_sum = sr + sbit;
    sq_ge  = (sn >= sq_sum);
    shx    = cx >>> cnt[4:0];
    shy    = cy >>> cnt[4:0];
    cang   = cordic_angle(cnt[4:0]);
    // rotation: turn toward z = 0; vectoring: turn toward y = 0
    csig   = cvec ? cy[DW-1] : !cz[DW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      busy          <= 1'b0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
      r_wb          <= 20'd98304;
      r_amax        <= 17'd39322;
      r_gain        <= 19'd19661;
      r_floor       <= 21'd98304;
      r_ceil        <= 22'd262144;
      r_thr         <= 19'd9830;
      r_step        <= 17'd1311;
      sl            <= WORD_BITS'(131072);
      last_angle    <= '0;
      last_neg      <= 1'b0;
      hold          <= '0;
      tight         <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

      if (busy) begin
        if (u_mul) begin
          if (mb[0]) macc <= macc + ma;
          ma <= ma <<< 1;
          mb <= mb >> 1;
        end
        if (u_div) begin
          drem <= div_ge ? div_sh - dd : div_sh;
          dn   <= {dn[62:0], div_ge};
        end
        if (u_sqrt) begin
          if (sq_ge) begin
            sn <= sn - sq_sum;
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
        end
        if (u_cor) begin
          if (csig) begin
            cx <= cx - shy;
            cy <= cy + shx;
            cz <= cz - cang;
          end else begin
            cx <= cx + shy;
            cy <= cy - shx;
            cz <= cz + cang;
          end
        end
        if (cnt == unit_last) begin
          busy  <= 1'b0;
          state <= state_after;
        end else begin
          cnt <= cnt + 7'd1;
        end
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            err_q <= in_err;
            spd_q <= in_spd;
            crv_q <= in_crv;
            ac_q  <= in_ac;
            ae_q  <= in_ae;
            // curve sign flip on a real bend arms the S-bend hold
            if (dword_t'(in_ac) > QC_03 && in_crv[23] != last_neg)
              hold <= 5'(BEND_HOLD_TICKS);
            last_neg <= in_crv[23];
            state    <= ST_MUL_BASE;
          end
        end
        ST_MUL_BASE: begin
          if (!busy) begin
            ma <= spd_w; mb <= MUL_BITS'(r_gain); macc <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_BASE_SET: begin
          base  <= WORD_BITS'(sat(dword_t'(r_floor) + (macc >>> FRACTION_BITS), WLIM));
          state <= (ac_w > dword_t'(r_thr)) ? ST_DIV_RATIO : ST_CAPS;
        end
        ST_DIV_RATIO: begin
          if (!busy) begin
            dn <= 64'(r_thr) << FRACTION_BITS; dd <= 64'(ac_q); drem <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_SQRT: begin
          if (!busy) begin
            sn <= dn << FRACTION_BITS; sr <= '0; sbit <= 64'd1 << 62;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_MUL_SHRINK: begin
          if (!busy) begin
            ma <= base_w; mb <= sr[MUL_BITS-1:0]; macc <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_SHRINK_SET: begin
          base  <= WORD_BITS'(imax(hair_w, macc >>> FRACTION_BITS));
          state <= ST_CAPS;
        end
        ST_CAPS: begin
          base <= WORD_BITS'(base_capped);
          emer <= (ac_w > QC_25);
          if (ac_w > QC_25) begin
            // emergency: blend toward the hairpin lookahead
            tight <= 1'b1;
            kq    <= 17'(QC_35);
            state <= ST_MUL_SM_A;
          end else if (hold != 5'd0) begin
            sl    <= WORD_BITS'(hair_w);
            hold  <= hold - 5'd1;
            tight <= 1'b1;
            state <= ST_LOOK;
          end else begin
            kq    <= tight ? 17'(QC_08) : 17'(QC_12);
            state <= ST_MUL_SM_A;
          end
        end
        ST_MUL_SM_A: begin
          if (!busy) begin
            ma <= sl_w; mb <= MUL_BITS'(ONE - dword_t'(kq)); macc <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_MUL_SM_B: begin
          if (!busy) begin
            tmp <= macc; ma <= emer ? tgt_w : base_w; mb <= MUL_BITS'(kq); macc <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_SM_SET: begin
          sl <= WORD_BITS'(sat(sm_nl, WLIM));
          if (!emer) tight <= 1'b0;
          state <= ST_LOOK;
        end
        ST_LOOK: begin
          dyn   <= 22'(look_dyn);
          state <= ST_TAN;
        end
        ST_TAN: begin
          if (!busy) begin
            cx <= CORDIC_ONE; cy <= '0;
            cz <= amax_w <<< (ANGLE_Q - FRACTION_BITS); cvec <= 1'b0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_DIV_TAN: begin
          if (!busy) begin
            dn   <= cy[DW-1] ? 64'd0 : (64'(cy) << FRACTION_BITS);
            dd   <= (cx <= 0) ? 64'd1 : 64'(cx);
            drem <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_DIV_MAXC: begin
          if (!busy) begin
            dn   <= dn << FRACTION_BITS;
            dd   <= (r_wb == 20'd0) ? 64'd1 : 64'(r_wb);
            drem <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_REQ_SEL: begin
          maxc <= maxc_new[38:0];
          if (dyn == 22'd0) begin
            req   <= (ae_q != 24'd0) ? maxc_new[38:0] : 39'd0;
            state <= ST_MUL_FB;
          end else begin
            state <= ST_DIV_T;
          end
        end
        ST_DIV_T: begin
          if (!busy) begin
            dn <= 64'(ae_q) << (FRACTION_BITS + 1); dd <= 64'(dyn); drem <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_DIV_REQ: begin
          if (!busy) begin
            dn <= t_sat << FRACTION_BITS; dd <= 64'(dyn); drem <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_REQ_SET: begin
          req   <= (dn > 64'(maxc)) ? maxc : dn[38:0];
          state <= ST_MUL_FB;
        end
        ST_MUL_FB: begin
          if (!busy) begin
            ma <= err_q[23] ? -dword_t'(req) : dword_t'(req);
            mb <= MUL_BITS'(r_wb); macc <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_ATAN_FB, ST_ATAN_FF: begin
          if (!busy) begin
            cx <= CORDIC_ONE; cy <= atan_arg <<< (ANGLE_Q - FRACTION_BITS);
            cz <= '0; cvec <= 1'b1;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_MUL_FF: begin
          if (!busy) begin
            fb <= 18'(atan_round);
            ma <= crv_w; mb <= MUL_BITS'(r_wb); macc <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_FF_SET: begin
          ff    <= 18'(atan_round);
          wreg  <= w_new;
          state <= ST_MUL_W_A;
        end
        ST_MUL_W_A: begin
          if (!busy) begin
            ma <= ff_w; mb <= MUL_BITS'(wreg); macc <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_MUL_W_B: begin
          if (!busy) begin
            tmp <= macc; ma <= fb_w; mb <= MUL_BITS'(ONE - dword_t'(wreg)); macc <= '0;
            busy <= 1'b1; cnt <= '0;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {dyn, 18'(fin_ang)};
            m_axis_tuser  <= tight;
            m_axis_tvalid <= 1'b1;
            last_angle    <= 18'(fin_ang);
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_WHEELBASE:  r_wb    <= cfg_data[19:0];
          REG_MAX_ANGLE:  r_amax  <= cfg_data[16:0];
          REG_SPEED_GAIN: r_gain  <= cfg_data[18:0];
          REG_LA_FLOOR:   r_floor <= cfg_data[20:0];
          REG_LA_CEIL:    r_ceil  <= cfg_data[21:0];
          REG_BEND_THR:   r_thr   <= cfg_data[18:0];
          REG_STEP_LIMIT: r_step  <= cfg_data[16:0];
          REG_START_LA:   sl      <= WORD_BITS'(cfg_data);
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- design/ppsc_checker.sv -----
module ppsc_checker
  import ppsc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [21:0] cfg_data
);

  localparam logic signed [17:0] ANG_LIM = 18'(ONE);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // one tick in flight: input closes right after a transaction
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a tick is in flight");

  // steering angle never leaves +-1 rad
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[17:0]) <= ANG_LIM) && ($signed(m_axis_tdata[17:0]) >= -ANG_LIM))
    else $error("steering angle out of range");

endmodule

bind pure_pursuit_steering_controller_top ppsc_checker u_ppsc_checker (.*);

// ----- tb/pure_pursuit_steering_controller_top_test.sv -----
module pure_pursuit_steering_controller_top_test;
  import ppsc_pkg::*;

  // Stream-side timing knobs. No tick is taken while one is in flight, so the
  // idling mostly matters for where the gaps fall relative to the output.
  localparam int  IDLE_PCT   = 19;
  localparam int  RAND_ITEMS = 1530;
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [21:0] cfg_data;

  // One expected steering result
  typedef struct packed {
    logic [17:0] angle;
    logic [21:0] lookahead;
    logic        tight;
  } steer_result_t;

  steer_result_t steer_expected_q[$];
  int     fail_count;
  longint cycle_count;
  bit     calm_sink; // stretch with no receiver stalls

  // Controller registers and state, mirrored at the block's widths
  logic [19:0] wheelbase_r;
  logic [16:0] max_angle_r;
  logic [18:0] speed_gain_r;
  logic [20:0] la_floor_r;
  logic [21:0] la_ceil_r;
  logic [18:0] bend_thr_r;
  logic [16:0] step_limit_r;
  logic [21:0] start_la_r;
  longint      smooth_la;
  longint      prev_angle;
  bit          prev_curve_neg;
  int          hold_ticks;
  bit          tight_state;

  pure_pursuit_steering_controller_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------- fixed-point helpers ----------------

  // round toward minus infinity
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint rot_angle(int i);
    longint t[10] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                      64'h003FFFEA, 64'h001FFFFD};
    if (i < 10) return t[i];
    return (longint'(1) << (30 - i)) - 1;
  endfunction

  // tangent of [0,1] rad by rotation, Q16 in and out
  function automatic longint tan_q16(longint a);
    longint x, y, z, nx, ny;
    x = longint'(1) << 30;
    y = 0;
    z = a << 14;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i);
        ny = y + asr(x, i);
        z -= rot_angle(i);
      end else begin
        nx = x + asr(y, i);
        ny = y - asr(x, i);
        z += rot_angle(i);
      end
      x = nx;
      y = ny;
    end
    if (y < 0) y = 0;
    if (x <= 0) x = 1;
    return (y << 16) / x;
  endfunction

  // arctangent by vectoring, Q16 in and out, rounded to nearest
  function automatic longint atan_q16(longint v);
    longint x, y, z, nx, ny;
    v = clip(v, longint'(1) << 36);
    x = longint'(1) << 30;
    z = 0;
    y = (v >= 0) ? (v << 14) : -((-v) << 14);
    for (int i = 0; i < 30; i++) begin
      if (y >= 0) begin
        nx = x + asr(y, i);
        ny = y - asr(x, i);
        z += rot_angle(i);
      end else begin
        nx = x - asr(y, i);
        ny = y + asr(x, i);
        z -= rot_angle(i);
      end
      x = nx;
      y = ny;
    end
    return asr(z + (longint'(1) << 13), 14);
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic void mirror_reset();
    wheelbase_r    = 20'd98304;
    max_angle_r    = 17'd39322;
    speed_gain_r   = 19'd19661;
    la_floor_r     = 21'd98304;
    la_ceil_r      = 22'd262144;
    bend_thr_r     = 19'd9830;
    step_limit_r   = 17'd1311;
    start_la_r     = 22'd131072;
    smooth_la      = 131072;
    prev_angle     = 0;
    prev_curve_neg = 0;
    hold_ticks     = 0;
    tight_state    = 0;
  endfunction

  function automatic void mirror_write(reg_idx_t idx, logic [21:0] v);
    case (idx)
      REG_WHEELBASE:  wheelbase_r  = v[19:0];
      REG_MAX_ANGLE:  max_angle_r  = v[16:0];
      REG_SPEED_GAIN: speed_gain_r = v[18:0];
      REG_LA_FLOOR:   la_floor_r   = v[20:0];
      REG_LA_CEIL:    la_ceil_r    = v[21:0];
      REG_BEND_THR:   bend_thr_r   = v[18:0];
      REG_STEP_LIMIT: step_limit_r = v[16:0];
      REG_START_LA: begin
        start_la_r = v[21:0];
        smooth_la  = longint'(v[21:0]);
      end
      default: ;
    endcase
  endfunction

  // One control tick: update the lookahead state, then the steering angle.
  function automatic steer_result_t steer_tick(logic signed [23:0] lat_err,
                                               logic signed [23:0] speed,
                                               logic signed [23:0] curve);
    steer_result_t res;
    longint err, spd, crv, wb, wbd, amax, flo, cei, thr, stp, ac, ae, hair;
    longint base, dyn, cap, maxc, req, fb, ff, w, ang, delta, k, nl, t, fac;
    longint unsigned ratio;
    bit neg, same;
    err  = longint'(lat_err);
    spd  = longint'(speed);
    crv  = longint'(curve);
    wb   = longint'(wheelbase_r);
    wbd  = (wb != 0) ? wb : 1;
    amax = lmin(longint'(max_angle_r), ONE);
    flo  = longint'(la_floor_r);
    cei  = longint'(la_ceil_r);
    thr  = longint'(bend_thr_r);
    stp  = longint'(step_limit_r);
    ac   = (crv < 0) ? -crv : crv;
    ae   = (err < 0) ? -err : err;
    neg  = crv < 0;
    hair = lmax((wb * 3) >> 1, flo);

    base = clip(flo + asr(longint'(speed_gain_r) * spd, 16), WLIM);
    // curvature sign flip starts the S-bend hold
    if (ac > QC_03 && neg != prev_curve_neg) hold_ticks = BEND_HOLD_TICKS;
    prev_curve_neg = neg;
    if (ac > thr) begin
      ratio = (longint'(thr) << 16) / ac;
      fac   = root_floor(ratio << 16);
      base  = lmax(hair, asr(base * fac, 16));
    end
    if (ac > QC_05) base = lmin(base, LA_3M);
    if (ac > QC_15) base = lmin(base, LA_2M);

    if (ac > QC_25) begin
      smooth_la = asr(smooth_la * (ONE - QC_35) + lmin(hair, cei) * QC_35, 16);
      tight_state = 1;
    end else if (hold_ticks > 0) begin
      smooth_la = hair;
      hold_ticks--;
      tight_state = 1;
    end else begin
      k  = tight_state ? QC_08 : QC_12;
      nl = asr(smooth_la * (ONE - k) + base * k, 16);
      if (tight_state) nl = lmin(nl, base);
      smooth_la = nl;
      tight_state = 0;
    end
    smooth_la = clip(smooth_la, WLIM);

    dyn = lmin(lmax(smooth_la, hair), cei);
    cap = (ac < QC_05) ? cei : ((ac < QC_15) ? LA_3M : LA_2M);
    dyn = lmin(dyn, cap);

    maxc = lmin((tan_q16(amax) << 16) / wbd, TLIM);
    if (dyn <= 0) begin
      req = (ae != 0) ? maxc : 0;
    end else begin
      t   = lmin(((2 * ae) << 16) / dyn, TLIM);
      req = lmin((t << 16) / dyn, maxc);
    end
    if (err < 0) req = -req;

    fb   = atan_q16(asr(wb * req, 16));
    ff   = atan_q16(asr(wb * crv, 16));
    same = (fb >= 0 && ff >= 0) || (fb <= 0 && ff <= 0);
    w    = same ? QC_20 : 0;
    if (ac > QC_05 && ac < QC_20 && same) w = QC_40;
    if (ae < QC_20 && same) w = lmax(w, QC_30);
    ang = clip(asr(ff * w + fb * (ONE - w), 16), amax);

    delta = ang - prev_angle;
    if (delta > stp) ang = prev_angle + stp;
    else if (delta < -stp) ang = prev_angle - stp;
    ang = clip(ang, amax);
    prev_angle = ang;

    res.angle     = ang[17:0];
    res.lookahead = dyn[21:0];
    res.tight     = tight_state;
    return res;
  endfunction

  // ---------------- stimulus ----------------

  // Send one tick; the expectation is computed at acceptance so that config
  // writes issued while idle are already in the mirror. The block takes no new
  // tick while one is in flight, so the trailing wait costs nothing.
  task automatic send_tick(logic signed [23:0] e, logic signed [23:0] v,
                           logic signed [23:0] c);
    while (!calm_sink && $urandom_range(99) < IDLE_PCT) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, v, e};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    steer_expected_q.push_back(steer_tick(e, v, c));
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result plus the block's tail before a write.
  task automatic drain();
    while (steer_expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [21:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    mirror_write(idx, v);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_field();
    case ($urandom_range(5))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(131072)) - 65536);
      2: return 24'($signed($urandom_range(40000)) - 20000);
      3: return 24'($signed($urandom_range(600000)) - 300000);
      4: return ($urandom_range(1)) ? 24'sh7FFFFF : -24'sh800000;
      default: return 24'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  // curvature that moves through straight, curve, hairpin and S-bend ranges
  function automatic logic signed [23:0] rand_curve();
    int m;
    m = $urandom_range(9);
    if (m < 3) return 24'($signed($urandom_range(6000)) - 3000);
    if (m < 6) return 24'($signed($urandom_range(30000)) - 15000);
    if (m < 8) return 24'($signed($urandom_range(60000)) - 30000);
    return rand_field();
  endfunction

  task automatic test_directed();
    send_tick(24'sd0, 24'sd0, 24'sd0);
    send_tick(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_tick(-24'sh800000, -24'sh800000, -24'sh800000);
    send_tick(24'sd65536, 24'sd655360, 24'sd1000);       // straight, large error
    send_tick(-24'sd65536, 24'sd655360, 24'sd5000);      // moderate curve
    send_tick(24'sd6000, 24'sd300000, 24'sd12000);       // small error, mid curve
    send_tick(24'sd6000, 24'sd300000, -24'sd12000);      // sign flip starts the hold
    repeat (3) send_tick(-24'sd5000, 24'sd300000, -24'sd12000);
    send_tick(24'sd30000, 24'sd300000, 24'sd20000);      // hairpin blend
    send_tick(24'sd30000, 24'sd300000, -24'sd20000);
    send_tick(-24'sd30000, -24'sd200000, 24'sd0);        // reverse speed
    send_tick(24'sd0, 24'sd100000, 24'sd1966);           // curve at the S-bend threshold
    send_tick(24'sd100, 24'sd100000, -24'sd1967);        // just above it
    send_tick(24'sd1, 24'sd1, 24'sd3277);                // lookahead cap edges
    send_tick(-24'sd1, 24'sd1, 24'sd9830);
    send_tick(24'sd200000, 24'sd0, -24'sd16384);
  endtask

  task automatic random_ticks(int n);
    logic signed [23:0] c;
    for (int i = 0; i < n; i++) begin
      c = rand_curve();
      send_tick(rand_field(), rand_field(), c);
    end
  endtask

  task automatic test_register_extremes();
    drain();
    write_reg(REG_WHEELBASE, 22'd16384);
    write_reg(REG_MAX_ANGLE, 22'd65536);
    write_reg(REG_SPEED_GAIN, 22'd262144);
    write_reg(REG_LA_FLOOR, 22'd1);
    write_reg(REG_LA_CEIL, 22'd2);
    write_reg(REG_BEND_THR, 22'd1);
    write_reg(REG_STEP_LIMIT, 22'd65536);
    write_reg(REG_START_LA, 22'd32768);
    random_ticks(120);
    drain();
    write_reg(REG_WHEELBASE, 22'd524288);
    write_reg(REG_MAX_ANGLE, 22'd1);
    write_reg(REG_SPEED_GAIN, 22'd1);
    write_reg(REG_LA_FLOOR, 22'd1048576);
    write_reg(REG_LA_CEIL, 22'd2097152);
    write_reg(REG_BEND_THR, 22'd262144);
    write_reg(REG_STEP_LIMIT, 22'd1);
    write_reg(REG_START_LA, 22'd2097152);
    random_ticks(120);
    drain();
    // floor above ceiling: the ceiling wins
    write_reg(REG_LA_FLOOR, 22'd500000);
    write_reg(REG_LA_CEIL, 22'd100000);
    write_reg(REG_STEP_LIMIT, 22'd3000);
    write_reg(REG_MAX_ANGLE, 22'd50000);
    random_ticks(100);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(REG_WHEELBASE, 22'($urandom_range(524288, 16384)));
      write_reg(REG_MAX_ANGLE, 22'($urandom_range(65536, 1)));
      write_reg(REG_SPEED_GAIN, 22'($urandom_range(262144, 1)));
      write_reg(REG_LA_FLOOR, 22'($urandom_range(300000, 1)));
      write_reg(REG_LA_CEIL, 22'($urandom_range(600000, 2)));
      write_reg(REG_BEND_THR, 22'($urandom_range(40000, 1)));
      write_reg(REG_STEP_LIMIT, 22'($urandom_range(65536, 1)));
      write_reg(REG_START_LA, 22'($urandom_range(600000, 32768)));
      calm_sink = (p == 2);
      random_ticks(RAND_ITEMS / 10);
    end
    calm_sink = 0;
    drain();
    // back to the defaults for the long run
    write_reg(REG_WHEELBASE, 22'd98304);
    write_reg(REG_MAX_ANGLE, 22'd39322);
    write_reg(REG_SPEED_GAIN, 22'd19661);
    write_reg(REG_LA_FLOOR, 22'd98304);
    write_reg(REG_LA_CEIL, 22'd262144);
    write_reg(REG_BEND_THR, 22'd9830);
    write_reg(REG_STEP_LIMIT, 22'd1311);
    write_reg(REG_START_LA, 22'd131072);
    random_ticks(RAND_ITEMS - 340 - 6 * (RAND_ITEMS / 10));
  endtask

  // ---------------- result checking ----------------

  // receiver stalls, skipped during the calm stretch
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm_sink || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    steer_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (steer_expected_q.size() == 0) begin
        $display("%0t: unexpected steering transaction %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        exp_r = steer_expected_q.pop_front();
        if (m_axis_tdata[17:0] !== exp_r.angle) begin
          $display("%0t: steer_angle expected %h actual %h",
                   $time, exp_r.angle, m_axis_tdata[17:0]);
          fail_count++;
        end
        if (m_axis_tdata[39:18] !== exp_r.lookahead) begin
          $display("%0t: lookahead_used expected %h actual %h",
                   $time, exp_r.lookahead, m_axis_tdata[39:18]);
          fail_count++;
        end
        if (m_axis_tuser[0] !== exp_r.tight) begin
          $display("%0t: tight_mode expected %b actual %b",
                   $time, exp_r.tight, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    fail_count    = 0;
    cycle_count   = 0;
    calm_sink     = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_WHEELBASE;
    cfg_data      = '0;
    mirror_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_random_settings();

    // let the last tick finish and catch any extra transaction
    drain();
    repeat (1000) @(posedge clk);
    if (fail_count == 0 && steer_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
